// ===== rtl/ors_pkg.sv =====
// Shared types, widths and constants for the octant restriction block.
package ors_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 19;
  localparam int COORD_W  = 7;
  localparam int SCALED_W = 18;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 5;
  // Wide enough for any grid size the block parameters allow
  localparam int SIZE_W   = 11;

  // 1/sqrt(8) in Q0.16, applied as a signed 17-bit operand
  localparam logic [15:0] INV_SQRT8_Q16 = 16'h5A82;
  localparam int K_W      = 17;
  localparam int PROD_W   = SUM_W + K_W;
  localparam int FRAC_SH  = 16;

  typedef enum logic [2:0] {
    REG_FINE_SIZE_Y   = 3'd0,
    REG_FINE_SIZE_Z   = 3'd1,
    REG_COARSE_SIZE_X = 3'd2,
    REG_COARSE_SIZE_Y = 3'd3,
    REG_COARSE_SIZE_Z = 3'd4,
    REG_OFFSET_X      = 3'd5,
    REG_OFFSET_Y      = 3'd6,
    REG_OFFSET_Z      = 3'd7
  } ors_reg_t;

  typedef struct packed {
    logic        [6:0] fine_size_y;
    logic        [6:0] fine_size_z;
    logic        [7:0] coarse_size_x;
    logic        [7:0] coarse_size_y;
    logic        [7:0] coarse_size_z;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic signed [7:0] offset_z;
  } ors_cfg_t;

  // One sample on its way to the accumulator
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                first;   // all coordinates even: overwrite entry
    logic                close;   // all coordinates odd: octant complete
    logic                emit;    // complete and inside the coarse grid
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  cz;
  } ors_req_t;

  // Finished octant sum heading to the scaler
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
  } ors_sum_t;

endpackage

// ===== rtl/ors_in_if.sv =====
// Input sample channel: valid/ready plus one fine sample and an end-of-field flag.
interface ors_in_if import ors_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] fine_sample;
  logic                       end_of_field;

  modport source (output valid, fine_sample, end_of_field, input ready);
  modport sink   (input valid, fine_sample, end_of_field, output ready);
endinterface

// ===== rtl/ors_out_if.sv =====
// Result channel: valid/ready plus one coarse cell and its value.
interface ors_out_if import ors_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [COORD_W-1:0]  coarse_x;
  logic        [COORD_W-1:0]  coarse_y;
  logic        [COORD_W-1:0]  coarse_z;
  logic signed [SCALED_W-1:0] scaled_sum;

  modport source (output valid, coarse_x, coarse_y, coarse_z, scaled_sum, input ready);
  modport sink   (input valid, coarse_x, coarse_y, coarse_z, scaled_sum, output ready);
endinterface

// ===== rtl/octant_restriction_3d_top.sv =====
// Top level of the 2x2x2 octant restriction block.
//
// in_ch takes fine samples in raster order (x outer, y, z inner), one beat per
// sample; end_of_field on the last beat restarts the position counters.
// Every sample is summed into its octant's entry of a partial-sum RAM. The
// eighth sample of an octant produces at most one out_ch beat: the offset
// coarse cell and the sum times 1/sqrt(8) in Q.0 (rounded integer); cells
// outside the coarse grid produce nothing. Registers go through the cfg_ APB
// port; the user must write them only while idle (not enforced by the block).
// Throughput: one sample per clock while out_ch does not stall. The RAM does
// one read (on accept) and one write (from the accumulate stage) per clock; a
// write that races the next read is forwarded. A result passes the accumulate
// stage, scaler and output register. When out_ch stalls, emitting beats back
// up through two stages; other samples flow until an emitting one meets it.
// Reset clears counters, pipeline valids and registers to their defaults.
// The partial-sum RAM needs no clearing: each octant's first sample
// overwrites its entry.
module octant_restriction_3d_top import ors_pkg::*; #(
  parameter int MAX_FINE_SIZE   = 64,
  parameter int MAX_COARSE_SIZE = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  ors_in_if.sink            in_ch,
  ors_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int ACC_DEPTH = (MAX_FINE_SIZE / 2) * (MAX_FINE_SIZE / 2);
  localparam int AW        = $clog2(ACC_DEPTH);

  ors_cfg_t      cfg;
  logic          req_valid, req_ready;
  ors_req_t      req;
  logic [AW-1:0] req_addr;
  logic          sum_valid, sum_ready;
  ors_sum_t      sum;

  ors_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ors_seq #(
    .MAX_FINE_SIZE   (MAX_FINE_SIZE),
    .MAX_COARSE_SIZE (MAX_COARSE_SIZE),
    .AW              (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .req_addr  (req_addr)
  );

  ors_accum #(
    .DEPTH (ACC_DEPTH),
    .AW    (AW)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .req_addr  (req_addr),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  ors_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .out_ch    (out_ch)
  );

  // A finished sum held back by the scaler stays put
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid && !sum_ready |=> sum_valid && $stable(sum))
    else $error("finished octant sum changed while stalled");

  // Only an emitting octant-completing beat may block the input
  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    !sum_valid |-> req_ready)
    else $error("input blocked with no completed octant pending");

  // An octant cannot both open and close on the same sample
  a_first_close: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> !(req.first && req.close))
    else $error("sample marked as both first and last of its octant");

  // An accepted emitting beat reaches the scaler handoff
  a_emit_close: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready && req.emit |=> sum_valid)
    else $error("emitting beat did not reach the scaler handoff");

endmodule

// ===== rtl/ors_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ors_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ors_cfg.sv =====
// APB register file holding grid sizes and offsets.
module ors_cfg import ors_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output ors_cfg_t          cfg
);

  ors_cfg_t cfg_r, cfg_nxt;
  ors_reg_t sel;
  logic     wr;

  assign sel    = ors_reg_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (sel)
        REG_FINE_SIZE_Y:   cfg_nxt.fine_size_y   = pwdata[6:0];
        REG_FINE_SIZE_Z:   cfg_nxt.fine_size_z   = pwdata[6:0];
        REG_COARSE_SIZE_X: cfg_nxt.coarse_size_x = pwdata[7:0];
        REG_COARSE_SIZE_Y: cfg_nxt.coarse_size_y = pwdata[7:0];
        REG_COARSE_SIZE_Z: cfg_nxt.coarse_size_z = pwdata[7:0];
        REG_OFFSET_X:      cfg_nxt.offset_x      = pwdata[7:0];
        REG_OFFSET_Y:      cfg_nxt.offset_y      = pwdata[7:0];
        REG_OFFSET_Z:      cfg_nxt.offset_z      = pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_size_y   <= 7'd64;
      cfg_r.fine_size_z   <= 7'd64;
      cfg_r.coarse_size_x <= 8'd128;
      cfg_r.coarse_size_y <= 8'd128;
      cfg_r.coarse_size_z <= 8'd128;
      cfg_r.offset_x      <= '0;
      cfg_r.offset_y      <= '0;
      cfg_r.offset_z      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (sel)
      REG_FINE_SIZE_Y:   prdata = CFG_DW'(cfg_r.fine_size_y);
      REG_FINE_SIZE_Z:   prdata = CFG_DW'(cfg_r.fine_size_z);
      REG_COARSE_SIZE_X: prdata = CFG_DW'(cfg_r.coarse_size_x);
      REG_COARSE_SIZE_Y: prdata = CFG_DW'(cfg_r.coarse_size_y);
      REG_COARSE_SIZE_Z: prdata = CFG_DW'(cfg_r.coarse_size_z);
      REG_OFFSET_X:      prdata = CFG_DW'(unsigned'(cfg_r.offset_x));
      REG_OFFSET_Y:      prdata = CFG_DW'(unsigned'(cfg_r.offset_y));
      REG_OFFSET_Z:      prdata = CFG_DW'(unsigned'(cfg_r.offset_z));
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ors_seq.sv =====
// Raster position counters, accumulator address and coarse cell placement.
module ors_seq import ors_pkg::*; #(
  parameter int MAX_FINE_SIZE   = 64,
  parameter int MAX_COARSE_SIZE = 128,
  parameter int AW              = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ors_cfg_t      cfg,
  ors_in_if.sink        in_ch,
  output logic          req_valid,
  input  logic          req_ready,
  output ors_req_t      req,
  output logic [AW-1:0] req_addr
);

  localparam int CW = $clog2(MAX_FINE_SIZE);
  localparam int EW = CW + 1;
  localparam int PW = CW - 1 + EW + 1;

  logic [CW-1:0] x_r, y_r, z_r;
  logic [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic [EW-1:0] ny, nz, half_z;
  logic [PW-1:0] lin;
  logic signed [SIZE_W:0] vx, vy, vz;
  logic          fire;

  // Clamp a fine size to the supported range
  function automatic logic [EW-1:0] fine_eff(input logic [6:0] s);
    logic [SIZE_W-1:0] w;
    w = SIZE_W'(s);
    if (w < SIZE_W'(2)) begin
      w = SIZE_W'(2);
    end else if (w > SIZE_W'(MAX_FINE_SIZE)) begin
      w = SIZE_W'(MAX_FINE_SIZE);
    end
    return w[EW-1:0];
  endfunction

  // Octant index plus signed offset
  function automatic logic signed [SIZE_W:0] shift_oct(input logic [CW-1:0] pos,
                                                       input logic signed [7:0] off);
    logic signed [SIZE_W:0] base;
    base = $signed({1'b0, SIZE_W'(pos >> 1)});
    return base + (SIZE_W+1)'(off);
  endfunction

  // Inside [0, clamped coarse size)
  function automatic logic in_grid(input logic signed [SIZE_W:0] v, input logic [7:0] size);
    logic [SIZE_W-1:0] lim;
    lim = (SIZE_W'(size) > SIZE_W'(MAX_COARSE_SIZE)) ? SIZE_W'(MAX_COARSE_SIZE)
                                                      : SIZE_W'(size);
    return !v[SIZE_W] && (v[SIZE_W-1:0] < lim);
  endfunction

  assign ny     = fine_eff(cfg.fine_size_y);
  assign nz     = fine_eff(cfg.fine_size_z);
  assign half_z = EW'((nz + EW'(1)) >> 1);

  // Accumulator entry: (y/2) * ceil(nz/2) + z/2
  assign lin      = PW'(y_r[CW-1:1] * half_z) + PW'(z_r[CW-1:1]);
  assign req_addr = lin[AW-1:0];

  assign vx = shift_oct(x_r, cfg.offset_x);
  assign vy = shift_oct(y_r, cfg.offset_y);
  assign vz = shift_oct(z_r, cfg.offset_z);

  // Request beat
  always_comb begin
    req.sample = in_ch.fine_sample;
    req.first  = !(x_r[0] || y_r[0] || z_r[0]);
    req.close  = x_r[0] && y_r[0] && z_r[0];
    req.emit   = req.close && in_grid(vx, cfg.coarse_size_x)
                 && in_grid(vy, cfg.coarse_size_y) && in_grid(vz, cfg.coarse_size_z);
    req.cx     = vx[COORD_W-1:0];
    req.cy     = vy[COORD_W-1:0];
    req.cz     = vz[COORD_W-1:0];
  end

  assign req_valid   = in_ch.valid;
  assign in_ch.ready = req_ready;
  assign fire        = in_ch.valid && req_ready;

  // Raster advance: z fastest, x slowest
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (fire) begin
      if (in_ch.end_of_field) begin
        x_nxt = '0;
        y_nxt = '0;
        z_nxt = '0;
      end else if ((EW'(z_r) + EW'(1)) < nz) begin
        z_nxt = z_r + CW'(1);
      end else begin
        z_nxt = '0;
        if ((EW'(y_r) + EW'(1)) < ny) begin
          y_nxt = y_r + CW'(1);
        end else begin
          y_nxt = '0;
          x_nxt = (x_r == CW'(MAX_FINE_SIZE - 1)) ? '0 : x_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

// ===== rtl/ors_accum.sv =====
// Read-modify-write of octant partial sums with write-to-read forwarding.
module ors_accum import ors_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  ors_req_t      req,
  input  logic [AW-1:0] req_addr,
  output logic          sum_valid,
  input  logic          sum_ready,
  output ors_sum_t      sum
);

  logic             s1_valid_r;
  ors_req_t         s1_req_r;
  logic [AW-1:0]    s1_addr_r;
  logic             fwd_valid_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [SUM_W-1:0] fwd_data_r;

  logic [SUM_W-1:0] rdata, base, acc, smp;
  logic             s1_go, rd_en;

  ors_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr_r),
    .wdata (acc),
    .re    (rd_en),
    .raddr (req_addr),
    .rdata (rdata)
  );

  // Read issued on the accept edge; data lands for stage 1
  assign rd_en = req_valid && req_ready;

  // Last write wins over the RAM read, which may predate it
  assign base = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rdata;
  assign smp  = {{(SUM_W-SAMPLE_W){s1_req_r.sample[SAMPLE_W-1]}}, s1_req_r.sample};
  assign acc  = s1_req_r.first ? smp : base + smp;

  // Non-emitting beats retire from stage 1 without waiting downstream
  assign s1_go     = s1_valid_r && (!s1_req_r.emit || sum_ready);
  assign req_ready = !s1_valid_r || s1_go;

  assign sum_valid = s1_valid_r && s1_req_r.emit;
  assign sum.sum   = acc;
  assign sum.cx    = s1_req_r.cx;
  assign sum.cy    = s1_req_r.cy;
  assign sum.cz    = s1_req_r.cz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid_r <= req_valid;
      end
      if (s1_go) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_req_r  <= req;
      s1_addr_r <= req_addr;
    end
    if (s1_go) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= acc;
    end
  end

endmodule

// ===== rtl/ors_scale.sv =====
// Scale by 1/sqrt(8) with round half up, then the output register.
module ors_scale import ors_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     sum_valid,
  output logic     sum_ready,
  input  ors_sum_t sum,
  ors_out_if.source out_ch
);

  logic                     s2_valid_r;
  ors_sum_t                 s2_r;
  logic                     out_valid_r;
  logic [COORD_W-1:0]       cx_r, cy_r, cz_r;
  logic [SCALED_W-1:0]      scaled_r;

  logic signed [SUM_W-1:0]  s2_sum;
  logic signed [PROD_W-1:0] prod, rnd;
  logic                     out_go, s2_ready;

  // Stage handshake
  assign out_go    = !out_valid_r || out_ch.ready;
  assign s2_ready  = !s2_valid_r || out_go;
  assign sum_ready = s2_ready;

  // Multiply, add half an LSB, take the integer (Q.0) bits
  assign s2_sum = s2_r.sum;
  assign prod   = PROD_W'(s2_sum) * PROD_W'($signed({1'b0, INV_SQRT8_Q16}));
  assign rnd    = prod + PROD_W'(1 << (FRAC_SH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= sum_valid;
      end
      if (out_go) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && sum_valid) begin
      s2_r <= sum;
    end
    if (out_go && s2_valid_r) begin
      cx_r     <= s2_r.cx;
      cy_r     <= s2_r.cy;
      cz_r     <= s2_r.cz;
      scaled_r <= rnd[FRAC_SH+SCALED_W-1:FRAC_SH];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coarse_x   = cx_r;
  assign out_ch.coarse_y   = cy_r;
  assign out_ch.coarse_z   = cz_r;
  assign out_ch.scaled_sum = scaled_r;

endmodule
